// ----- src/serial_frame_receiver_assert.svh -----
// Assertion macros shared by the serial frame receiver RTL.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SFR_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Condition that must never be seen outside reset.
`define SFR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define SFR_ASSERT_HOLDS(lbl, prop, msg)
`define SFR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/sfr_pkg.sv -----
// Types and constants shared by the serial frame receiver modules.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	// Frame framing bytes.
	localparam logic [7:0] START_B   = 8'h62;
	localparam logic [7:0] START_A   = 8'h61;
	localparam logic [7:0] RANGE_LEN = 8'd3;

	// Register indexes on the configuration port.
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_BAD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ID   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 4'd3;

	// Register reset values.
	localparam logic [7:0]  RANGE_ID_RST  = 8'h33;
	localparam logic [14:0] MAX_RANGE_RST = 15'd764;
	localparam logic [14:0] MIN_RANGE_RST = 15'd21;

	// Result item kinds.
	localparam logic [2:0] KIND_PAYLOAD     = 3'd0;
	localparam logic [2:0] KIND_GOOD        = 3'd1;
	localparam logic [2:0] KIND_BAD_REPORT  = 3'd2;
	localparam logic [2:0] KIND_BAD_DISCARD = 3'd3;
	localparam logic [2:0] KIND_RANGE       = 3'd4;

	// Range classification codes.
	localparam logic [1:0] RANGE_OK       = 2'd0;
	localparam logic [1:0] RANGE_TOO_FAR  = 2'd1;
	localparam logic [1:0] RANGE_TOO_NEAR = 2'd2;

	// Configuration register contents.
	typedef struct packed {
		logic        report_bad_frames;
		logic [7:0]  range_frame_id;
		logic [14:0] max_range_cm;
		logic [14:0] min_range_cm;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic [2:0]         item_kind;
		logic [7:0]         data_byte;
		logic [7:0]         byte_index;
		logic               frame_end;
		logic [7:0]         line_checksum;
		logic [7:0]         checksum_computed;
		logic signed [15:0] range_cm;
		logic [1:0]         range_status;
		logic [15:0]        good_frames;
		logic [15:0]        range_frames;
		logic [15:0]        bad_frames;
	} result_t;

endpackage

`default_nettype wire

// ----- src/sfr_cfg_regs.sv -----
// Configuration registers of the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module sfr_cfg_regs
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Register writes; indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_bad_frames <= 1'b0;
			cfg_q.range_frame_id    <= RANGE_ID_RST;
			cfg_q.max_range_cm      <= MAX_RANGE_RST;
			cfg_q.min_range_cm      <= MIN_RANGE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_REPORT_BAD: cfg_q.report_bad_frames <= cfg_data[0];
				CFG_RANGE_ID:   cfg_q.range_frame_id    <= cfg_data[7:0];
				CFG_MAX_RANGE:  cfg_q.max_range_cm      <= cfg_data[14:0];
				CFG_MIN_RANGE:  cfg_q.min_range_cm      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- src/sfr_parser.sv -----
// Frame parser: receive state, checksum, range decode and frame counters.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_receiver_assert.svh"

module sfr_parser
	import sfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] byte_in,
	input  wire logic       out_free,
	input  cfg_t            cfg,
	output logic            take,
	output logic            has_result,
	output result_t         result
);

	typedef enum logic [1:0] {PH_WAIT, PH_SIZE, PH_PAYLOAD, PH_CHECK} phase_t;

	phase_t      phase_q;
	logic [7:0]  frame_length_q;
	logic [7:0]  bytes_seen_q;
	logic [7:0]  running_sum_q;
	logic [7:0]  first_q [0:2];
	logic [15:0] good_q;
	logic [15:0] range_q;
	logic [15:0] bad_q;

	logic [7:0]         bytes_seen_inc;
	logic [7:0]         sum_add;
	logic               is_start;
	logic               sum_ok;
	logic               is_range;
	logic signed [15:0] range_val;
	logic [1:0]         status;
	logic [15:0]        good_n;
	logic [15:0]        range_n;
	logic [15:0]        bad_n;

	// Payload and checksum bytes produce a result and need the output register.
	assign has_result = (phase_q == PH_PAYLOAD) || (phase_q == PH_CHECK);
	assign take       = byte_valid && (!has_result || out_free);

	assign bytes_seen_inc = bytes_seen_q + 8'd1;
	assign sum_add        = running_sum_q + byte_in;
	assign is_start       = (byte_in == START_B) || (byte_in == START_A);
	assign sum_ok         = (running_sum_q == byte_in);
	assign is_range       = sum_ok && (frame_length_q == RANGE_LEN)
		&& (first_q[0] == cfg.range_frame_id);
	assign range_val      = $signed({first_q[1], first_q[2]});

	// Classify the range; the upper limit is tested first.
	always_comb begin
		if (range_val > $signed({1'b0, cfg.max_range_cm})) begin
			status = RANGE_TOO_FAR;
		end else if (range_val < $signed({1'b0, cfg.min_range_cm})) begin
			status = RANGE_TOO_NEAR;
		end else begin
			status = RANGE_OK;
		end
	end

	// Counter values after this byte's update.
	always_comb begin
		good_n  = good_q;
		range_n = range_q;
		bad_n   = bad_q;
		if (phase_q == PH_CHECK) begin
			if (!sum_ok) begin
				bad_n = bad_q + 16'd1;
			end else if (is_range) begin
				range_n = range_q + 16'd1;
			end else begin
				good_n = good_q + 16'd1;
			end
		end
	end

	// Result beat for payload and checksum bytes.
	always_comb begin
		result              = '0;
		result.good_frames  = good_n;
		result.range_frames = range_n;
		result.bad_frames   = bad_n;
		if (phase_q == PH_PAYLOAD) begin
			result.item_kind  = KIND_PAYLOAD;
			result.data_byte  = byte_in;
			result.byte_index = bytes_seen_q;
		end else begin
			result.frame_end         = 1'b1;
			result.line_checksum     = byte_in;
			result.checksum_computed = running_sum_q;
			if (!sum_ok) begin
				result.item_kind = cfg.report_bad_frames ? KIND_BAD_REPORT : KIND_BAD_DISCARD;
			end else if (is_range) begin
				result.item_kind    = KIND_RANGE;
				result.range_cm     = range_val;
				result.range_status = status;
			end else begin
				result.item_kind = KIND_GOOD;
			end
		end
	end

	// Receive state machine and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_WAIT;
			frame_length_q <= '0;
			bytes_seen_q   <= '0;
			running_sum_q  <= '0;
			first_q[0]     <= '0;
			first_q[1]     <= '0;
			first_q[2]     <= '0;
			good_q         <= '0;
			range_q        <= '0;
			bad_q          <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (is_start) begin
						running_sum_q <= byte_in;
						bytes_seen_q  <= '0;
						phase_q       <= PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (byte_in == 8'd0) begin
						phase_q <= PH_WAIT;
					end else begin
						frame_length_q <= byte_in;
						running_sum_q  <= sum_add;
						phase_q        <= PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (bytes_seen_q < 8'd3) begin
						first_q[bytes_seen_q[1:0]] <= byte_in;
					end
					running_sum_q <= sum_add;
					bytes_seen_q  <= bytes_seen_inc;
					if (bytes_seen_inc >= frame_length_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_WAIT;
					good_q  <= good_n;
					range_q <= range_n;
					bad_q   <= bad_n;
				end
				default: phase_q <= PH_WAIT;
			endcase
		end
	end

	`SFR_ASSERT_HOLDS(a_len_nonzero, (phase_q == PH_PAYLOAD) |-> (frame_length_q != 8'd0), "payload phase with zero frame length")
	`SFR_ASSERT_HOLDS(a_count_bound, (phase_q == PH_PAYLOAD) |-> (bytes_seen_q < frame_length_q), "payload count reached frame length without moving to checksum")
	`SFR_ASSERT_HOLDS(a_check_ends, (take && (phase_q == PH_CHECK)) |=> (phase_q == PH_WAIT), "frame did not close after checksum byte")

endmodule

`default_nettype wire

// ----- src/serial_frame_receiver.sv -----
// Top level of the serial frame receiver: input stage, parser and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_receiver_assert.svh"

// Serial frame receiver. Takes one received byte per beat and parses frames made
// of a start byte, a nonzero length, the payload and an 8-bit additive checksum.
// Every payload byte comes out as a beat of kind payload; the checksum byte closes
// the frame with one beat of kind good, bad or range. Start, length and stray
// bytes give no beat. The block sustains one byte per clock cycle while the output
// side does not stall: a byte is held in an input register, the parser updates its
// frame state, and the result is held in an output register. The user must write
// configuration registers through the plain write port only while no frame byte
// is in flight; the block itself does not enforce this.
module serial_frame_receiver
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 item_kind,
	output logic [7:0]                 data_byte,
	output logic [7:0]                 byte_index,
	output logic                       frame_end,
	output logic [7:0]                 line_checksum,
	output logic [7:0]                 checksum_computed,
	output logic signed [15:0]         range_cm,
	output logic [1:0]                 range_status,
	output logic [15:0]                good_frames,
	output logic [15:0]                range_frames,
	output logic [15:0]                bad_frames
);

	cfg_t    cfg;
	result_t result;
	result_t result_q;
	logic    valid_s1;
	logic [7:0] rx_byte_s1;
	logic    take;
	logic    has_result;
	logic    out_valid_q;
	logic    out_free;

	sfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (valid_s1),
		.byte_in    (rx_byte_s1),
		.out_free   (out_free),
		.cfg        (cfg),
		.take       (take),
		.has_result (has_result),
		.result     (result)
	);

	// The input stage holds its byte until the parser takes it.
	assign in_stall = valid_s1 && !take;
	assign out_free = !out_valid_q || !out_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Result register: loaded by a byte that produces a beat, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			result_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign item_kind         = result_q.item_kind;
	assign data_byte         = result_q.data_byte;
	assign byte_index        = result_q.byte_index;
	assign frame_end         = result_q.frame_end;
	assign line_checksum     = result_q.line_checksum;
	assign checksum_computed = result_q.checksum_computed;
	assign range_cm          = result_q.range_cm;
	assign range_status      = result_q.range_status;
	assign good_frames       = result_q.good_frames;
	assign range_frames      = result_q.range_frames;
	assign bad_frames        = result_q.bad_frames;

	`SFR_ASSERT_HOLDS(a_end_matches_kind, out_valid_q |-> (result_q.frame_end == (result_q.item_kind != KIND_PAYLOAD)), "frame_end disagrees with item kind")
	`SFR_ASSERT_HOLDS(a_stage_holds, (valid_s1 && !take) |=> valid_s1, "input stage dropped a byte the parser had not taken")
	`SFR_ASSERT_NEVER(a_no_overwrite, take && has_result && out_valid_q && out_stall, "result register overwritten while stalled")

endmodule

`default_nettype wire
